>>> rtl/core/assert_macros.svh
// Assertion macros for the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/core/xrg_pkg.sv
// Package with the constants, codes and types of the xorshift128 range generator.
package xrg_pkg;

   localparam int unsigned WordWidth     = 32;
   localparam int unsigned ModeWidth     = 3;
   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned SeedCount     = 4;
   localparam int unsigned SeedSelWidth  = $clog2(SeedCount);
   localparam int unsigned FracWidth     = 16;
   localparam int unsigned ReqDataWidth  = 2 * WordWidth;
   localparam int unsigned RspDataWidth  = 40;
   localparam int unsigned RspUserWidth  = 1;
   localparam int unsigned QueueDepth    = 2;
   localparam int unsigned QueuePtrWidth = $clog2(QueueDepth);
   localparam int unsigned QueueCntWidth = $clog2(QueueDepth + 1);
   localparam int unsigned DivCntWidth   = $clog2(WordWidth);

   localparam logic [SeedCount-1:0][WordWidth-1:0] SeedReset = {
      32'h0549_1333, 32'h1F12_3BB5, 32'h159A_55E5, 32'h075B_CD15
   };

   localparam logic [WordWidth-1:0] Low31Mask = 32'h7FFF_FFFF;

   localparam logic [ModeWidth-1:0] MODE_RAW      = 3'd0;
   localparam logic [ModeWidth-1:0] MODE_SIGNED   = 3'd1;
   localparam logic [ModeWidth-1:0] MODE_UNSIGNED = 3'd2;
   localparam logic [ModeWidth-1:0] MODE_FRACTION = 3'd3;
   localparam logic [ModeWidth-1:0] MODE_SCALED   = 3'd4;
   localparam logic [ModeWidth-1:0] MODE_CHANCE   = 3'd5;

   typedef enum logic [1:0] {
      OP_PASS = 2'd0,
      OP_MOD  = 2'd1,
      OP_MUL  = 2'd2
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [WordWidth-1:0]  operand;
      logic [WordWidth-1:0]  span;
      logic [WordWidth-1:0]  lower;
      logic                  hit;
      logic                  err;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

>>> rtl/core/xorshift128_range_generator.sv
// Top level of the xorshift128 range generator: front, queue and back joined.
//
// Each request, except a chance request with zero upper bound or an unused
// mode, draws one word from an xorshift128 generator and reduces it by the
// mode in req_tuser. The front takes a request whenever the two-entry queue
// has room, so up to two requests are taken while the back is busy. The back
// handles one request at a time: raw, fraction, chance and error results
// reach the response register in the next cycle, scaled results pass through
// dequeue, multiply, then add, and range results through dequeue, the 32
// steps of the radix-2 remainder unit and the final add. The back starts
// the next request once the previous response has been taken. A write to
// any seed register reloads all four generator words from the seeds.
module xorshift128_range_generator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: lower_bound [31:0], upper_bound [63:32]
   input  logic [xrg_pkg::ReqDataWidth-1:0]    req_tdata,
   // tuser: mode [2:0]
   input  logic [xrg_pkg::ModeWidth-1:0]       req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata: value [31:0], chance_hit [32], zero padding [39:33]
   output logic [xrg_pkg::RspDataWidth-1:0]    rsp_tdata,
   // tuser: divide_error [0]
   output logic [xrg_pkg::RspUserWidth-1:0]    rsp_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [xrg_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [xrg_pkg::WordWidth-1:0]       csr_data
);
   import xrg_pkg::*;

   push_type         push;
   logic             pop;
   item_type         head;
   queue_status_type status;

   xrg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .status     (status),
      .push       (push)
   );

   xrg_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .head   (head),
      .status (status)
   );

   xrg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .status     (status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> rtl/core/xrg_queue.sv
// Short queue of classified requests between the front and the back.
module xrg_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  xrg_pkg::push_type         push,
   input  logic                      pop,
   output xrg_pkg::item_type         head,
   output xrg_pkg::queue_status_type status
);
   import xrg_pkg::*;

   item_type                 entries_ff [QueueDepth];
   logic [QueuePtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueueCntWidth-1:0] count_ff, count_in;
   logic                     do_push, do_pop;

   assign status.full  = (count_ff == QueueCntWidth'(QueueDepth));
   assign status.empty = (count_ff == '0);
   assign head         = entries_ff[rd_ptr_ff];
   assign do_push      = push.valid && !status.full;
   assign do_pop       = pop && !status.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QueuePtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QueuePtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push.item;
      end
   end

endmodule

>>> rtl/core/xrg_front.sv
// Front part: seed registers, generator words, request intake and classification.
module xrg_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [xrg_pkg::ReqDataWidth-1:0]    req_tdata,
   input  logic [xrg_pkg::ModeWidth-1:0]       req_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [xrg_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [xrg_pkg::WordWidth-1:0]       csr_data,
   input  xrg_pkg::queue_status_type           status,
   output xrg_pkg::push_type                   push
);
   import xrg_pkg::*;

   logic [SeedCount-1:0][WordWidth-1:0] seed_ff, seed_in;
   logic [SeedCount-1:0][WordWidth-1:0] gen_ff, gen_in;
   logic [WordWidth-1:0]                lower, upper, span, mag, tmp, word;
   logic                                req_accept, csr_write, draw_needed;
   item_type                            item;

   assign req_tready = !status.full;
   assign csr_ready  = 1'b1;
   assign req_accept = req_tvalid && req_tready;
   assign csr_write  = csr_valid && csr_ready && (csr_index < CsrIndexWidth'(SeedCount));

   assign lower = req_tdata[WordWidth-1:0];
   assign upper = req_tdata[ReqDataWidth-1:WordWidth];
   assign span  = upper - lower;
   assign mag   = span[WordWidth-1] ? (WordWidth'(0) - span) : span;
   assign tmp   = gen_ff[0] ^ (gen_ff[0] << 11);
   assign word  = gen_ff[3] ^ (gen_ff[3] >> 19) ^ tmp ^ (tmp >> 8);

   always_comb begin
      item.op      = OP_PASS;
      item.operand = '0;
      item.span    = '0;
      item.lower   = lower;
      item.hit     = 1'b0;
      item.err     = 1'b0;
      draw_needed  = 1'b1;
      unique case (req_tuser)
         MODE_RAW: begin
            item.operand = word;
         end
         MODE_SIGNED: begin
            if (mag == '0) begin
               item.err = 1'b1;
            end else begin
               item.op      = OP_MOD;
               item.operand = word & Low31Mask;
               item.span    = mag;
            end
         end
         MODE_UNSIGNED: begin
            if (span == '0) begin
               item.err = 1'b1;
            end else begin
               item.op      = OP_MOD;
               item.operand = word;
               item.span    = span;
            end
         end
         MODE_FRACTION: begin
            item.operand = {{(WordWidth - FracWidth){1'b0}}, word[FracWidth-1:0]};
         end
         MODE_SCALED: begin
            item.op      = OP_MUL;
            item.operand = {{(WordWidth - FracWidth){1'b0}}, word[FracWidth-1:0]};
            item.span    = span;
         end
         MODE_CHANCE: begin
            draw_needed = (upper != '0);
            item.hit    = draw_needed &&
                          ({{(WordWidth - FracWidth){1'b0}}, word[FracWidth-1:0]} <= upper);
         end
         default: begin
            draw_needed = 1'b0;
         end
      endcase
   end

   assign push.valid = req_accept;
   assign push.item  = item;

   always_comb begin
      seed_in = seed_ff;
      gen_in  = gen_ff;
      if (csr_write) begin
         seed_in[csr_index[SeedSelWidth-1:0]] = csr_data;
         gen_in = seed_in;
      end else if (req_accept && draw_needed) begin
         gen_in = {word, gen_ff[3], gen_ff[2], gen_ff[1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= SeedReset;
         gen_ff  <= SeedReset;
      end else begin
         seed_ff <= seed_in;
         gen_ff  <= gen_in;
      end
   end

endmodule

>>> rtl/core/xrg_back.sv
// Back part: radix-2 remainder unit, scaling multiplier and response register.
module xrg_back (
   input  logic                               clock,
   input  logic                               reset,
   input  xrg_pkg::item_type                  head,
   input  xrg_pkg::queue_status_type          status,
   output logic                               pop,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [xrg_pkg::RspDataWidth-1:0]   rsp_tdata,
   output logic [xrg_pkg::RspUserWidth-1:0]   rsp_tuser
);
   import xrg_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_MUL  = 4'b0100,
      ST_SUM  = 4'b1000
   } state_type;

   state_type                state_ff, state_in;
   logic [DivCntWidth-1:0]   count_ff, count_in;
   logic [WordWidth-1:0]     quot_ff, quot_in;
   logic [WordWidth-1:0]     rem_ff, rem_in;
   logic [WordWidth-1:0]     span_ff, span_in;
   logic [WordWidth-1:0]     lower_ff, lower_in;
   logic                     valid_ff, valid_in;
   logic [WordWidth-1:0]     value_ff, value_in;
   logic                     hit_ff, hit_in;
   logic                     err_ff, err_in;
   logic [WordWidth:0]       trial, diff;
   logic signed [WordWidth+FracWidth:0] product;

   assign trial   = {rem_ff, quot_ff[WordWidth-1]};
   assign diff    = trial - {1'b0, span_ff};
   assign product = $signed({{(FracWidth + 1){span_ff[WordWidth-1]}}, span_ff}) *
                    $signed({{WordWidth{1'b0}}, quot_ff[FracWidth-1:0]});
   assign pop     = (state_ff == ST_IDLE) && !status.empty && !valid_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      span_in  = span_ff;
      lower_in = lower_ff;
      valid_in = valid_ff;
      value_in = value_ff;
      hit_in   = hit_ff;
      err_in   = err_ff;
      if (valid_ff && rsp_tready) begin
         valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               quot_in  = head.operand;
               span_in  = head.span;
               lower_in = head.lower;
               rem_in   = '0;
               count_in = DivCntWidth'(WordWidth - 1);
               unique case (head.op)
                  OP_MOD: state_in = ST_DIV;
                  OP_MUL: state_in = ST_MUL;
                  default: begin
                     valid_in = 1'b1;
                     value_in = head.operand;
                     hit_in   = head.hit;
                     err_in   = head.err;
                  end
               endcase
            end
         end
         ST_DIV: begin
            rem_in  = diff[WordWidth] ? trial[WordWidth-1:0] : diff[WordWidth-1:0];
            quot_in = quot_ff << 1;
            if (count_ff == '0) begin
               state_in = ST_SUM;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         ST_MUL: begin
            rem_in   = product[WordWidth+FracWidth-1:FracWidth];
            state_in = ST_SUM;
         end
         ST_SUM: begin
            valid_in = 1'b1;
            value_in = lower_ff + rem_ff;
            hit_in   = 1'b0;
            err_in   = 1'b0;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      span_ff  <= span_in;
      lower_ff <= lower_in;
      value_ff <= value_in;
      hit_ff   <= hit_in;
      err_ff   <= err_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(RspDataWidth - WordWidth - 1){1'b0}}, hit_ff, value_ff};
   assign rsp_tuser  = err_ff;

endmodule

>>> rtl/core/xrg_checker.sv
// Port-level checker for the xorshift128 range generator, bound to the top level.
`include "assert_macros.svh"

module xrg_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [xrg_pkg::RspDataWidth-1:0]    rsp_tdata,
   input logic [xrg_pkg::RspUserWidth-1:0]    rsp_tuser
);
   import xrg_pkg::*;

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   `ASSERT_SAME(a_err_clean, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tdata[WordWidth:0] == '0)
   `ASSERT_SAME(a_hit_clean, clock, reset, rsp_tvalid && rsp_tdata[WordWidth], (rsp_tdata[WordWidth-1:0] == '0) && !rsp_tuser[0])
   `ASSERT_SAME(a_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[RspDataWidth-1:WordWidth+1] == '0)

endmodule

bind xorshift128_range_generator xrg_checker u_checker (.*);

>>> sim/testbench.sv
// Self-checking testbench for the xorshift128 range generator, with its own predictor.
module testbench;
   import xrg_pkg::*;

   localparam logic [ModeWidth-1:0] MODE_SPARE_LOW  = 3'd6;
   localparam logic [ModeWidth-1:0] MODE_SPARE_HIGH = 3'd7;

   localparam logic [CsrIndexWidth-1:0] CSR_SEED0        = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_SEED1        = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_SEED2        = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_SEED3        = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_UNMAPPED     = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_UNMAPPED_TOP = 3'd7;

   localparam int CycleLimit   = 1000000;
   localparam int SettleCycles = 40;
   localparam int HoldCycles   = 400;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_type;

   typedef struct packed {
      logic [WordWidth-1:0] value;
      logic                 hit;
      logic                 err;
   } rng_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [ReqDataWidth-1:0]  req_tdata = '0;
   logic [ModeWidth-1:0]     req_tuser = MODE_RAW;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RspDataWidth-1:0]  rsp_tdata;
   logic [RspUserWidth-1:0]  rsp_tuser;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index = CSR_SEED0;
   logic [WordWidth-1:0]     csr_data = '0;

   logic [WordWidth-1:0] seed_regs [SeedCount];
   logic [WordWidth-1:0] gen_state [SeedCount];
   rng_result_type       expected_results [$];
   int                   error_count = 0;
   int                   cycle_count = 0;
   int                   burst_left = 0;
   bit                   idle_enable = 1'b1;
   stall_style_type      stall_style = STALL_NONE;
   int                   holdoffs_requested = 0;
   int                   holdoffs_granted = 0;
   int                   hold_left = 0;

   xorshift128_range_generator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void reload_generator();
      for (int i = 0; i < SeedCount; i++) gen_state[i] = seed_regs[i];
   endfunction

   function automatic logic [WordWidth-1:0] next_word();
      logic [WordWidth-1:0] t;
      t = gen_state[0] ^ (gen_state[0] << 11);
      gen_state[0] = gen_state[1];
      gen_state[1] = gen_state[2];
      gen_state[2] = gen_state[3];
      gen_state[3] = gen_state[3] ^ (gen_state[3] >> 19) ^ t ^ (t >> 8);
      return gen_state[3];
   endfunction

   function automatic rng_result_type reduce_request(logic [ModeWidth-1:0] mode,
                                                     logic [WordWidth-1:0] lo,
                                                     logic [WordWidth-1:0] hi);
      rng_result_type       r;
      logic [WordWidth-1:0] span;
      logic [WordWidth-1:0] word;
      logic [WordWidth-1:0] mag;
      longint               scaled;
      r = '0;
      span = hi - lo;
      case (mode)
         MODE_RAW: begin
            r.value = next_word();
         end
         MODE_SIGNED: begin
            word = next_word() & Low31Mask;
            mag = span[WordWidth-1] ? -span : span;
            if (mag == 0) r.err = 1'b1;
            else r.value = lo + word % mag;
         end
         MODE_UNSIGNED: begin
            word = next_word();
            if (span == 0) r.err = 1'b1;
            else r.value = lo + word % span;
         end
         MODE_FRACTION: begin
            word = next_word();
            r.value = {16'h0000, word[FracWidth-1:0]};
         end
         MODE_SCALED: begin
            word = next_word();
            scaled = longint'($signed(span)) * longint'(word[FracWidth-1:0]);
            r.value = lo + scaled[47:16];
         end
         MODE_CHANCE: begin
            if (hi != 0) begin
               word = next_word();
               r.hit = ({16'h0000, word[FracWidth-1:0]} <= hi);
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   function automatic logic [WordWidth-1:0] random_bound();
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         4: return $urandom_range(0, 255);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_request(input logic [ModeWidth-1:0] mode,
                               input logic [WordWidth-1:0] lo,
                               input logic [WordWidth-1:0] hi);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {hi, lo};
      do @(posedge clock); while (!req_tready);
      expected_results.push_back(reduce_request(mode, lo, hi));
      if (burst_left != 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         if (idle_enable) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_random_request();
      logic [ModeWidth-1:0] mode;
      logic [WordWidth-1:0] lo;
      logic [WordWidth-1:0] hi;
      if ($urandom_range(0, 15) == 0) begin
         mode = ModeWidth'($urandom_range(MODE_SPARE_LOW, MODE_SPARE_HIGH));
      end else begin
         mode = ModeWidth'($urandom_range(MODE_RAW, MODE_CHANCE));
      end
      lo = random_bound();
      case ($urandom_range(0, 3))
         0: hi = lo + $urandom_range(0, 300);
         1: hi = random_bound();
         2: hi = (mode == MODE_CHANCE) ? $urandom_range(0, 32'h1_FFFF) : $urandom;
         default: hi = $urandom;
      endcase
      send_request(mode, lo, hi);
   endtask

   task automatic finish_stream();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_seed_register(input logic [CsrIndexWidth-1:0] index,
                                      input logic [WordWidth-1:0] data);
      finish_stream();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index < SeedCount) begin
         seed_regs[index[SeedSelWidth-1:0]] = data;
         reload_generator();
      end
   endtask

   // Reset seeds: every mode with its boundary cases.
   task automatic test_directed_modes();
      stall_style = STALL_LIGHT;
      idle_enable = 1'b1;
      send_request(MODE_RAW, 32'h0000_0000, 32'h0000_0000);
      send_request(MODE_RAW, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(MODE_SIGNED, 32'h0000_0000, 32'h0000_000A);
      send_request(MODE_SIGNED, 32'h0000_0064, 32'hFFFF_FFF0);
      send_request(MODE_SIGNED, 32'h8000_0000, 32'h0000_0000);
      send_request(MODE_SIGNED, 32'h0000_0005, 32'h0000_0005);
      send_request(MODE_SIGNED, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_request(MODE_UNSIGNED, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(MODE_UNSIGNED, 32'h0000_0007, 32'h0000_0008);
      send_request(MODE_UNSIGNED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(MODE_UNSIGNED, 32'h0000_000A, 32'h0000_0003);
      send_request(MODE_FRACTION, 32'hFFFF_FFFF, 32'h0000_0000);
      send_request(MODE_SCALED, 32'h0000_0000, 32'h0001_0000);
      send_request(MODE_SCALED, 32'h0005_0000, 32'hFFFB_0000);
      send_request(MODE_SCALED, 32'h0000_0000, 32'h7FFF_FFFF);
      send_request(MODE_SCALED, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_request(MODE_CHANCE, 32'h0000_0000, 32'h0000_0000);
      send_request(MODE_CHANCE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(MODE_CHANCE, 32'h0000_0000, 32'h0000_0001);
      send_request(MODE_CHANCE, 32'h0000_0000, 32'h0000_8000);
      send_request(MODE_CHANCE, 32'h0000_0000, 32'h0001_0000);
      send_request(MODE_SPARE_LOW, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(MODE_SPARE_HIGH, 32'h0000_0000, 32'h0000_0000);
   endtask

   // Seeds at both extremes, and writes to indexes that hold no register.
   task automatic test_seed_registers();
      stall_style = STALL_NONE;
      idle_enable = 1'b0;
      for (int i = 0; i < SeedCount; i++) begin
         write_seed_register(CsrIndexWidth'(i), 32'hFFFF_FFFF);
      end
      repeat (6) send_random_request();
      write_seed_register(CSR_UNMAPPED, 32'h1234_5678);
      repeat (6) send_random_request();
      write_seed_register(CSR_UNMAPPED_TOP, 32'h0000_0000);
      repeat (6) send_random_request();
      write_seed_register(CSR_SEED0, 32'h0000_0000);
      write_seed_register(CSR_SEED1, 32'h0000_0000);
      write_seed_register(CSR_SEED2, 32'h0000_0000);
      write_seed_register(CSR_SEED3, 32'h0000_0000);
      repeat (8) send_random_request();
   endtask

   // Random seeds per phase, with random traffic shapes on both sides.
   task automatic test_random_requests();
      for (int phase = 0; phase < 6; phase++) begin
         if ($urandom_range(0, 1) == 0) begin
            write_seed_register(CsrIndexWidth'($urandom_range(CSR_SEED0, CSR_SEED3)), $urandom);
         end else begin
            for (int i = 0; i < SeedCount; i++) begin
               write_seed_register(CsrIndexWidth'(i), $urandom);
            end
         end
         stall_style = stall_style_type'($urandom_range(STALL_NONE, STALL_PERIODIC));
         idle_enable = $urandom_range(0, 3) != 0;
         repeat (250) send_random_request();
      end
   endtask

   // The receiver holds off long enough for the block to fill and stall requests.
   task automatic test_response_holdoff();
      write_seed_register(CSR_SEED2, $urandom);
      stall_style = STALL_NONE;
      idle_enable = 1'b0;
      holdoffs_requested <= holdoffs_requested + 1;
      repeat (40) send_random_request();
   endtask

   always @(posedge clock) begin
      if (holdoffs_requested != holdoffs_granted) begin
         hold_left <= HoldCycles;
         holdoffs_granted <= holdoffs_requested;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset || hold_left != 0 || holdoffs_requested != holdoffs_granted) begin
         rsp_tready <= 1'b0;
      end else begin
         case (stall_style)
            STALL_LIGHT:    rsp_tready <= $urandom_range(0, 3) != 0;
            STALL_HEAVY:    rsp_tready <= $urandom_range(0, 3) == 0;
            STALL_PERIODIC: rsp_tready <= (cycle_count % 7) < 4;
            default:        rsp_tready <= 1'b1;
         endcase
      end
   end

   always @(posedge clock) begin : check_responses
      rng_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: response with no request outstanding, value %h",
                     $time, rsp_tdata[WordWidth-1:0]);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_tdata[WordWidth-1:0] !== want.value) begin
               $display("%0t: value expected %h, actual %h",
                        $time, want.value, rsp_tdata[WordWidth-1:0]);
               error_count++;
            end
            if (rsp_tdata[WordWidth] !== want.hit) begin
               $display("%0t: chance_hit expected %b, actual %b",
                        $time, want.hit, rsp_tdata[WordWidth]);
               error_count++;
            end
            if (rsp_tuser[0] !== want.err) begin
               $display("%0t: divide_error expected %b, actual %b",
                        $time, want.err, rsp_tuser[0]);
               error_count++;
            end
         end
      end
   end

   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count <= cycle_count + 1;
      end
      $display("[xorshift128_range_generator] ERROR");
      $finish;
   end

   initial begin
      for (int i = 0; i < SeedCount; i++) seed_regs[i] = SeedReset[i];
      reload_generator();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_modes();
      test_seed_registers();
      test_random_requests();
      test_response_holdoff();
      finish_stream();
      if (expected_results.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, expected_results.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("[xorshift128_range_generator] OK");
      end else begin
         $display("[xorshift128_range_generator] ERROR");
      end
      $finish;
   end

endmodule
